>>> hw/rtl/dtc_pkg.sv
// dtc_pkg: shared types, constants and helpers for the temperature calibration block
// no dependencies; imported by every module of the block
`default_nettype none

package dtc_pkg;

  localparam int unsigned CodeW = 14;
  localparam int unsigned DataW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WarmW = 15;
  localparam int unsigned WARMUP_LIMIT_DEF = 30000;

  localparam int unsigned DieNumW = 29;
  localparam int unsigned DieDenW = 16;
  localparam int unsigned MagW = 17;
  localparam int unsigned RampNumW = MagW + WarmW;
  localparam int unsigned RampDenW = 16;

  localparam logic [DieDenW-1:0] SENSOR_DIV = 16'd28;
  localparam logic [RampDenW-1:0] RAMP_BIAS = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZERO_CODE   = 3'd0,
    REG_SENS_OFFSET = 3'd1,
    REG_SENS_SLOPE  = 3'd2,
    REG_CHIP_PCB    = 3'd3,
    REG_PCB_SHELL   = 3'd4,
    REG_DISP_OFFSET = 3'd5,
    REG_NORMAL_TEMP = 3'd6,
    REG_COMP_EN     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] zero_code;
    logic signed [15:0] sens_offset;
    logic        [15:0] sens_slope;
    logic signed [15:0] chip_pcb;
    logic signed [15:0] pcb_shell;
    logic signed [15:0] disp_offset;
    logic signed [7:0]  normal_temp;
    logic               comp_en;
  } cfg_t;

  function automatic logic [DataW-1:0] sat16(input logic signed [30:0] x);
    logic [DataW-1:0] r;
    if (x > 31'sd32767) begin
      r = 16'h7FFF;
    end else if (x < -31'sd32768) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dtc_cfg.sv
// dtc_cfg: configuration register bank with write port
// depends on dtc_pkg
`default_nettype none

module dtc_cfg
  import dtc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_code   <= '0;
      cfg_q.sens_offset <= '0;
      cfg_q.sens_slope  <= 16'd256;
      cfg_q.chip_pcb    <= '0;
      cfg_q.pcb_shell   <= '0;
      cfg_q.disp_offset <= '0;
      cfg_q.normal_temp <= '0;
      cfg_q.comp_en     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_ZERO_CODE:   cfg_q.zero_code   <= cfg_wdata_i;
        REG_SENS_OFFSET: cfg_q.sens_offset <= cfg_wdata_i;
        REG_SENS_SLOPE:  cfg_q.sens_slope  <= cfg_wdata_i;
        REG_CHIP_PCB:    cfg_q.chip_pcb    <= cfg_wdata_i;
        REG_PCB_SHELL:   cfg_q.pcb_shell   <= cfg_wdata_i;
        REG_DISP_OFFSET: cfg_q.disp_offset <= cfg_wdata_i;
        REG_NORMAL_TEMP: cfg_q.normal_temp <= cfg_wdata_i[7:0];
        REG_COMP_EN:     cfg_q.comp_en     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/dtc_div.sv
// dtc_div: bit-serial restoring divider, one quotient bit per cycle
// depends on dtc_pkg (import only); unsigned operands
`default_nettype none

module dtc_div
  import dtc_pkg::*;
#(
  parameter int unsigned NumW = DieNumW,
  parameter int unsigned DenW = DieDenW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] dividend_i,
  input  wire logic [DenW-1:0] divisor_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;

  logic [DenW:0]   shifted;
  logic [DenW+1:0] diff;
  logic            fits;

  assign shifted = {rem_q, num_q[NumW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = !diff[DenW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(NumW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CntW'(1);
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DenW-1:0] : shifted[DenW-1:0];
      num_q <= {num_q[NumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

`default_nettype wire

>>> hw/rtl/dtc_mul.sv
// dtc_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on dtc_pkg (import only); unsigned operands
`default_nettype none

module dtc_mul
  import dtc_pkg::*;
#(
  parameter int unsigned AW = MagW,
  parameter int unsigned BW = WarmW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic                  done_o,
  output logic [AW+BW-1:0]      product_o
);

  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW-1:0]   a_q;
  logic [AW-1:0]   hi_q;
  logic [BW-1:0]   lo_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [AW:0]     psum;

  assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(BW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CntW'(1);
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= psum[AW:1];
      lo_q <= {psum[0], lo_q[BW-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

`default_nettype wire

>>> hw/rtl/dom_temperature_calibrate.sv
// dom_temperature_calibrate: sensor code to die, chip and display temperature in Q8 degrees
// depends on dtc_pkg, dtc_cfg, dtc_div, dtc_mul
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_stall_o    sensor_code_i
//   out       source     out_valid_o / out_stall_i  display_temp_o, chip_temp_o, temp_high_o
//   cfg       sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// the die path runs two serial divisions (by 28, then by the slope) on one shared divider,
// with a prep state (ST_PREP2) between them
// the ramp path (serial multiply, then serial divide) runs alongside
// in_stall_o is high from a transfer until the result enters the output register
// the output register holds a result while out_stall_i is high; no clearing pass after reset
`default_nettype none

module dom_temperature_calibrate
  import dtc_pkg::*;
#(
  parameter int unsigned WARMUP_LIMIT = WARMUP_LIMIT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CodeW-1:0]   sensor_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [DataW-1:0] display_temp_o,
  output logic signed [DataW-1:0] chip_temp_o,
  output logic                    temp_high_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_PREP2,
    ST_DIV2,
    ST_FIN
  } state_e;

  cfg_t cfg;

  dtc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  state_e                    state_q;
  logic [WarmW-1:0]          warm_q;
  logic [WarmW-1:0]          warm_d;
  logic                      neg_q;
  logic                      sum_neg_q;
  logic signed [MagW:0]      sum_q;
  logic [RampDenW-1:0]       ramp_den_q;
  logic signed [MagW:0]      ramp_q;
  logic                      ramp_ok_q;
  logic signed [20:0]        v_q;
  logic signed [DieNumW-1:0] die_q;
  logic                      flag_q;
  logic                      out_valid_q;
  logic [DataW-1:0]          disp_q;
  logic [DataW-1:0]          chip_q;

  logic                      in_xfer;
  logic                      out_free;
  logic                      fin_go;

  logic signed [17:0]        raw;
  logic [17:0]               raw_mag;
  logic signed [MagW:0]      sum;
  logic [MagW:0]             sum_mag;
  logic signed [21:0]        t;
  logic [21:0]               t_mag;

  logic                      div_a_start;
  logic [DieNumW-1:0]        div_a_num;
  logic [DieDenW-1:0]        div_a_den;
  logic                      div_a_done;
  logic [DieNumW-1:0]        div_a_q;

  logic                      mul_done;
  logic [RampNumW-1:0]       mul_p;
  logic                      div_b_done;
  logic [RampNumW-1:0]       div_b_q;

  logic signed [30:0]        die_x;
  logic signed [30:0]        chip_w;
  logic signed [30:0]        disp_w;
  logic signed [8:0]         cen9;
  logic signed [8:0]         lo9;
  logic signed [8:0]         hi9;
  logic signed [DieNumW-1:0] lo_thr;
  logic signed [DieNumW-1:0] hi_thr;
  logic                      flag_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_go     = (state_q == ST_FIN) && ramp_ok_q && out_free;

  // warm-up tick, saturating one above the limit
  assign warm_d = (warm_q <= WarmW'(WARMUP_LIMIT)) ? warm_q + WarmW'(1) : warm_q;

  // accept-cycle front end
  assign raw     = $signed({2'b00, sensor_code_i, 2'b00}) - $signed({2'b00, cfg.zero_code});
  assign raw_mag = raw[17] ? 18'(-raw) : raw;
  assign sum     = $signed({cfg.pcb_shell[15], cfg.pcb_shell})
                 + $signed({cfg.disp_offset[15], cfg.disp_offset});
  assign sum_mag = sum[MagW] ? (MagW+1)'(-sum) : sum;

  // offset correction before the slope divide
  assign t     = $signed({v_q[20], v_q}) - $signed({{6{cfg.sens_offset[15]}}, cfg.sens_offset});
  assign t_mag = t[21] ? 22'(-t) : t;

  assign div_a_start = in_xfer || (state_q == ST_PREP2);
  assign div_a_num   = (state_q == ST_IDLE) ? {4'b0000, raw_mag[16:0], 8'h00}
                                            : {1'b0, t_mag[19:0], 8'h00};
  assign div_a_den   = (state_q == ST_IDLE) ? SENSOR_DIV
                     : ((cfg.sens_slope == '0) ? DieDenW'(1) : cfg.sens_slope);

  dtc_div #(
    .NumW (DieNumW),
    .DenW (DieDenW)
  ) u_div_die (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_a_start),
    .dividend_i (div_a_num),
    .divisor_i  (div_a_den),
    .done_o     (div_a_done),
    .quotient_o (div_a_q)
  );

  dtc_mul #(
    .AW (MagW),
    .BW (WarmW)
  ) u_mul_ramp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_xfer),
    .a_i       (sum_mag[MagW-1:0]),
    .b_i       (warm_d),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  dtc_div #(
    .NumW (RampNumW),
    .DenW (RampDenW)
  ) u_div_ramp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_done),
    .dividend_i (mul_p),
    .divisor_i  (ramp_den_q),
    .done_o     (div_b_done),
    .quotient_o (div_b_q)
  );

  // final offsets, saturation and hysteresis
  assign die_x  = {{2{die_q[DieNumW-1]}}, die_q};
  assign chip_w = die_x - $signed({{15{cfg.chip_pcb[15]}}, cfg.chip_pcb})
                        - $signed({{15{cfg.pcb_shell[15]}}, cfg.pcb_shell});
  assign disp_w = die_x - $signed({{15{cfg.chip_pcb[15]}}, cfg.chip_pcb})
                        - $signed({{13{ramp_q[MagW]}}, ramp_q});
  assign cen9   = $signed({cfg.normal_temp[7], cfg.normal_temp});
  assign lo9    = cen9 - 9'sd1;
  assign hi9    = cen9 + 9'sd1;
  assign lo_thr = $signed({{12{lo9[8]}}, lo9, 8'h00});
  assign hi_thr = $signed({{12{hi9[8]}}, hi9, 8'h00});

  always_comb begin
    flag_d = flag_q;
    if (die_q < lo_thr) begin
      flag_d = 1'b0;
    end else if (die_q > hi_thr) begin
      flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      warm_q      <= '0;
      neg_q       <= 1'b0;
      sum_neg_q   <= 1'b0;
      sum_q       <= '0;
      ramp_den_q  <= '0;
      ramp_q      <= '0;
      ramp_ok_q   <= 1'b0;
      v_q         <= '0;
      die_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      disp_q      <= '0;
      chip_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (div_b_done) begin
        ramp_ok_q <= 1'b1;
        if (cfg.comp_en) begin
          ramp_q <= sum_neg_q ? $signed(-{1'b0, div_b_q[MagW-1:0]})
                              : $signed({1'b0, div_b_q[MagW-1:0]});
        end else begin
          ramp_q <= sum_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            warm_q     <= warm_d;
            neg_q      <= raw[17];
            sum_neg_q  <= sum[MagW];
            sum_q      <= sum;
            ramp_den_q <= {1'b0, warm_d} + RAMP_BIAS;
            ramp_ok_q  <= 1'b0;
            state_q    <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_a_done) begin
            v_q     <= neg_q ? $signed(21'(-div_a_q[20:0])) : $signed(div_a_q[20:0]);
            state_q <= ST_PREP2;
          end
        end
        ST_PREP2: begin
          neg_q   <= t[21];
          state_q <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div_a_done) begin
            die_q   <= neg_q ? $signed(-div_a_q) : $signed(div_a_q);
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            chip_q      <= sat16(chip_w);
            disp_q      <= sat16(disp_w);
            flag_q      <= flag_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign display_temp_o = disp_q;
  assign chip_temp_o    = chip_q;
  assign temp_high_o    = flag_q;

  a_xfer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input transfer did not start a calculation");

  a_warm_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_q <= WarmW'(WARMUP_LIMIT + 1))
    else $error("warm-up count passed its ceiling");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside the final step");

  a_ramp_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && !ramp_ok_q |=> !$past(fin_go))
    else $error("result written before the ramp term was ready");

endmodule

`default_nettype wire

>>> tb/sv/dom_temperature_calibrate_test.sv
// dom_temperature_calibrate_test: self-checking testbench for the temperature calibration block
// drives sensor codes and register writes, predicts every result in-line and checks each transfer
// depends on dtc_pkg and the dom_temperature_calibrate rtl
`default_nettype none

module dom_temperature_calibrate_test
  import dtc_pkg::*;
();

  // warm-up ceiling as built
  localparam int unsigned WARMUP_CAP = WARMUP_LIMIT_DEF;
  localparam int HOLD_CYCLES = 700;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic signed [DataW-1:0] disp;
    logic signed [DataW-1:0] chip;
    logic                    high;
  } temp_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = REG_ZERO_CODE;
  logic [DataW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CodeW-1:0]   sensor_code_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [DataW-1:0] display_temp_o;
  logic signed [DataW-1:0] chip_temp_o;
  logic               temp_high_o;

  cfg_t             settings;
  logic [WarmW-1:0] warmup_n = '0;
  logic             level_high = 1'b0;
  temp_result_t     expected_temps[$];
  int               failures = 0;
  int               burst_left = 0;
  int               hold_requests = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  int               mode_left = 0;
  int               stall_pct = 0;

  dom_temperature_calibrate #(
    .WARMUP_LIMIT(WARMUP_CAP)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sensor_code_i (sensor_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .display_temp_o(display_temp_o),
    .chip_temp_o   (chip_temp_o),
    .temp_high_o   (temp_high_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic signed [DataW-1:0] clamp16(input longint x);
    if (x > 32767) begin
      return 16'sh7FFF;
    end else if (x < -32768) begin
      return 16'sh8000;
    end
    return x[DataW-1:0];
  endfunction

  // advances warm-up and flag state for one transfer
  function automatic temp_result_t calibrate_temps(input logic [CodeW-1:0] code);
    temp_result_t r;
    longint raw, scaled, slope, die, center, shift, ramp, n;
    if (warmup_n <= WARMUP_CAP) begin
      warmup_n = warmup_n + 1'b1;
    end
    n = longint'(warmup_n);
    raw = longint'(code) * 4 - longint'(settings.zero_code);
    scaled = (raw * 256) / 28;
    slope = (settings.sens_slope == '0) ? 1 : longint'(settings.sens_slope);
    die = ((scaled - longint'(settings.sens_offset)) * 256) / slope;
    r.chip = clamp16(die - longint'(settings.chip_pcb) - longint'(settings.pcb_shell));
    center = longint'(settings.normal_temp);
    if (die < (center - 1) * 256) begin
      level_high = 1'b0;
    end else if (die > (center + 1) * 256) begin
      level_high = 1'b1;
    end
    shift = longint'(settings.pcb_shell) + longint'(settings.disp_offset);
    ramp = settings.comp_en ? (shift * n) / (n + 1000) : shift;
    r.disp = clamp16(die - longint'(settings.chip_pcb) - ramp);
    r.high = level_high;
    return r;
  endfunction

  function automatic cfg_t default_settings();
    cfg_t c;
    c = '0;
    c.sens_slope = 16'd256;
    c.comp_en = 1'b1;
    return c;
  endfunction

  function automatic logic [DataW-1:0] pick_word(input logic [DataW-1:0] lo,
                                                 input logic [DataW-1:0] hi,
                                                 input logic [DataW-1:0] typ);
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return DataW'($urandom);
      default: return typ;
    endcase
  endfunction

  function automatic logic [DataW-1:0] near_zero(input int span);
    return DataW'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.zero_code   = pick_word(16'h0000, 16'hFFFF, DataW'($urandom_range(40000, 20000)));
    c.sens_offset = pick_word(16'h8000, 16'h7FFF, near_zero(2000));
    c.sens_slope  = pick_word(DataW'($urandom_range(1)), 16'hFFFF,
                              DataW'($urandom_range(360, 180)));
    c.chip_pcb    = pick_word(16'h8000, 16'h7FFF, near_zero(1500));
    c.pcb_shell   = pick_word(16'h8000, 16'h7FFF, near_zero(1500));
    c.disp_offset = pick_word(16'h8000, 16'h7FFF, near_zero(1500));
    c.normal_temp = 8'(pick_word(16'hFF80, 16'h007F, DataW'(int'($urandom_range(60)) - 10)));
    c.comp_en     = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endtask

  // all tasks below are entered and left just after a rising edge
  task automatic send_code(input logic [CodeW-1:0] code);
    in_valid_i <= 1'b1;
    sensor_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    expected_temps.push_back(calibrate_temps(code));
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(90, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_temps.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // bits above the narrow registers carry noise that the block must drop
  task automatic load_settings(input cfg_t c);
    wait_for_drain();
    write_reg(REG_ZERO_CODE, c.zero_code);
    write_reg(REG_SENS_OFFSET, c.sens_offset);
    write_reg(REG_SENS_SLOPE, c.sens_slope);
    write_reg(REG_CHIP_PCB, c.chip_pcb);
    write_reg(REG_PCB_SHELL, c.pcb_shell);
    write_reg(REG_DISP_OFFSET, c.disp_offset);
    write_reg(REG_NORMAL_TEMP, {8'($urandom), c.normal_temp});
    write_reg(REG_COMP_EN, {15'($urandom), c.comp_en});
    cfg_we_i <= 1'b0;
    settings = c;
  endtask

  task automatic test_reset_defaults();
    send_code(14'd0);
    send_code(14'h3FFF);
    send_code(14'h2AAA);
    send_code(14'h1555);
  endtask

  task automatic test_extremes();
    cfg_t c;
    c = default_settings();
    c.zero_code = 16'hFFFF;
    c.sens_slope = 16'd1;
    c.sens_offset = 16'sh7FFF;
    load_settings(c);
    send_code(14'd0);
    send_code(14'h3FFF);
    c = default_settings();
    c.sens_slope = 16'd0;
    c.sens_offset = 16'sh8000;
    c.chip_pcb = 16'sh8000;
    c.pcb_shell = 16'sh8000;
    c.disp_offset = 16'sh7FFF;
    c.normal_temp = 8'sh7F;
    c.comp_en = 1'b0;
    load_settings(c);
    send_code(14'h3FFF);
    send_code(14'd0);
    c = default_settings();
    c.sens_slope = 16'hFFFF;
    c.chip_pcb = 16'sh7FFF;
    c.pcb_shell = 16'sh7FFF;
    c.disp_offset = 16'sh8000;
    c.normal_temp = 8'sh80;
    load_settings(c);
    send_code(14'd0);
    send_code(14'h3FFF);
    send_code(14'h1FFF);
  endtask

  // band edges at 1 and 3 degrees: codes 7 and 21 land exactly on them
  task automatic test_hysteresis();
    cfg_t c;
    c = default_settings();
    c.normal_temp = 8'sd2;
    load_settings(c);
    send_code(14'd21);
    send_code(14'd22);
    send_code(14'd21);
    send_code(14'd7);
    send_code(14'd6);
    send_code(14'd7);
    send_code(14'd21);
  endtask

  task automatic test_compensation();
    cfg_t c;
    c = default_settings();
    c.pcb_shell = 16'sd20000;
    c.disp_offset = 16'sd12000;
    c.chip_pcb = -16'sd300;
    c.comp_en = 1'b0;
    load_settings(c);
    send_code(14'd100);
    send_code(14'd900);
    c.comp_en = 1'b1;
    load_settings(c);
    send_code(14'd100);
    send_code(14'd900);
  endtask

  // output held off while codes keep coming, so the input side backs up
  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 10; i++) begin
      send_code(CodeW'($urandom));
    end
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int base;
    int x;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_settings(random_settings());
      base = int'(settings.zero_code) / 4;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(1) == 0) begin
          x = $urandom_range(16383);
        end else begin
          x = base + int'($urandom_range(600)) - 300;
          x = (x < 0) ? 0 : ((x > 16383) ? 16383 : x);
        end
        pace_sender();
        send_code(CodeW'(x));
      end
    end
  endtask

  always @(posedge clk_i) begin : result_sink
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(300, 20);
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    temp_result_t got;
    temp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.disp = display_temp_o;
      got.chip = chip_temp_o;
      got.high = temp_high_o;
      if (expected_temps.size() == 0) begin
        note_failure($sformatf("unexpected transfer: display %0d chip %0d high %0b",
                               got.disp, got.chip, got.high));
      end else begin
        want = expected_temps.pop_front();
        if (got.disp !== want.disp || got.chip !== want.chip || got.high !== want.high) begin
          note_failure($sformatf(
            "mismatch (exp/got): display %0d/%0d chip %0d/%0d high %0b/%0b",
            want.disp, got.disp, want.chip, got.chip, want.high, got.high));
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("dom_temperature_calibrate verification failed");
    $finish;
  end

  initial begin : run
    settings = default_settings();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_hysteresis();
    test_compensation();
    test_backpressure();
    test_random_traffic();
    wait_for_drain();
    repeat (80) @(posedge clk_i);
    if (failures == 0 && expected_temps.size() == 0) begin
      $display("dom_temperature_calibrate verification clean");
    end else begin
      $display("dom_temperature_calibrate verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
